FILE: src/tile_region_cache_allocator_top_macros.svh
// Assertion macros for the tile region cache allocator.
`ifndef TILE_REGION_CACHE_ALLOCATOR_TOP_MACROS_SVH
`define TILE_REGION_CACHE_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TRC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define TRC_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TRC_ASSERT(label, clk, rst, prop, msg)
`define TRC_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

FILE: src/trc_pkg.sv
`timescale 1ns / 1ps
package trc_pkg;
   localparam int MAX_BLOCKS = 128;
   localparam int INDEX_BITS = 11;
   localparam int PTR_BITS   = $clog2(MAX_BLOCKS);
   localparam int CNT_BITS   = 8;
   localparam int POS_BITS   = INDEX_BITS + 1;
   localparam int ENT_BITS   = 24 + INDEX_BITS + 12;

   localparam logic [2:0] FUNC_ALLOC   = 3'd0;
   localparam logic [2:0] FUNC_REALLOC = 3'd1;
   localparam logic [2:0] FUNC_FREE    = 3'd2;
   localparam logic [2:0] FUNC_LOOKUP  = 3'd3;
   localparam logic [2:0] FUNC_FLUSH   = 3'd4;
   localparam logic [2:0] FUNC_CLEAR   = 3'd5;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_NO_ENTRY = 2'd2;
   localparam logic [1:0] ST_NO_SPACE = 2'd3;

   localparam logic [1:0] CSR_START = 2'd0;
   localparam logic [1:0] CSR_SIZE  = 2'd1;
   localparam logic [1:0] CSR_NBLK  = 2'd2;

   typedef struct packed {
      logic [2:0]  func;
      logic [23:0] tileset_id;
      logic [11:0] tile_count;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [INDEX_BITS-1:0] tile_index;
   } rsp_type;

   typedef struct packed {
      logic [23:0]           key;
      logic [INDEX_BITS-1:0] base;
      logic [11:0]           size;
   } entry_type;
endpackage

FILE: src/trc_ram.sv
`timescale 1ns / 1ps
module trc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: src/tile_region_cache_allocator_top.sv
`timescale 1ns / 1ps
// Flush, clear and unknown codes go straight from dispatch to the response state.
// A table walk reads entries in read, wait and check states (key lookup, conflict scan,
// drop scan); it then moves dropped entries, swaps or inserts, and writes the held entry when idle.
// Alloc miss: one conflict scan over the fixed entries per candidate position.
// Throughput: one request at a time; the next beat is taken once the result is issued and any held write is done.
// Reset: synchronous, active high; counts, search position and window start clear to zero.
module tile_region_cache_allocator_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  trc_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output trc_pkg::rsp_type  rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [11:0]       csr_wdata
);
   import trc_pkg::*;
   `include "tile_region_cache_allocator_top_macros.svh"

   typedef enum logic [4:0] {
      S_IDLE, S_DISP, S_FIND_RD, S_FIND_WT, S_FIND_CHK,
      S_REV_RD, S_REV_WT, S_REV_W1,
      S_SRCH_INIT, S_CF_RD, S_CF_WT, S_CF_CHK,
      S_DR_INIT, S_DR_RD, S_DR_WT, S_DR_CHK, S_DR_CPWT,
      S_INS_RD, S_INS_WT, S_INS_W,
      S_FR_RD, S_FR_WT, S_FR_W1,
      S_DONE
   } state_type;

   state_type             state_ff;
   logic [10:0]           start_ff;
   logic [11:0]           size_ff;
   logic [7:0]            nblk_ff;
   logic [CNT_BITS-1:0]   fixed_ff, kept_ff, last_ff;
   logic [POS_BITS-1:0]   spos_ff;
   req_type               req_ff;
   rsp_type               rsp_ff;
   rsp_type               res_ff;
   logic                  rsp_valid_ff;
   logic [CNT_BITS:0]     i_ff;
   logic [CNT_BITS-1:0]   hit_ff, lim_cnt_ff;
   entry_type             hold_ff;
   logic [POS_BITS:0]     s_ff, hi_pass_ff;
   logic                  pass2_ff;
   logic                  find_free_ff;

   // deferred write of the held entry, done in the idle cycle after the move
   logic                  hold_pending_ff;
   logic [PTR_BITS-1:0]   hold_addr_ff;

   logic                  wr_en;
   logic [PTR_BITS-1:0]   wr_addr, rd_addr;
   entry_type             wr_data, rd_data;

   trc_ram #(.WIDTH(ENT_BITS), .DEPTH(MAX_BLOCKS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   logic [CNT_BITS-1:0] used;
   logic [POS_BITS:0]   limit, start_x, cnt_x, s_end, e_end, b_x;
   logic                overlap;
   assign used    = (nblk_ff > 8'(MAX_BLOCKS)) ? CNT_BITS'(MAX_BLOCKS) : nblk_ff;
   assign start_x = (POS_BITS+1)'(start_ff);
   assign cnt_x   = (POS_BITS+1)'(req_ff.tile_count);
   assign limit   = ((start_x + (POS_BITS+1)'(size_ff)) > (POS_BITS+1)'(1 << INDEX_BITS))
                    ? (POS_BITS+1)'(1 << INDEX_BITS) : start_x + (POS_BITS+1)'(size_ff);
   assign s_end   = s_ff + cnt_x;
   assign b_x     = (POS_BITS+1)'(rd_data.base);
   assign e_end   = b_x + (POS_BITS+1)'(rd_data.size);
   assign overlap = (b_x < s_end) && (e_end > s_ff);

   assign req_stall = (state_ff != S_IDLE) || hold_pending_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = rd_data;
      rd_addr = i_ff[PTR_BITS-1:0];
      unique case (state_ff)
         S_REV_RD, S_FR_RD: rd_addr = last_ff[PTR_BITS-1:0];
         S_REV_WT, S_FR_WT: rd_addr = last_ff[PTR_BITS-1:0];
         S_REV_W1: begin
            wr_en = 1'b1; wr_addr = hit_ff[PTR_BITS-1:0]; wr_data = rd_data;
         end
         S_FR_W1: begin
            wr_en = 1'b1; wr_addr = hit_ff[PTR_BITS-1:0]; wr_data = rd_data;
         end
         S_DR_CHK: begin
            rd_addr = PTR_BITS'(last_ff - 1'b1);
         end
         S_DR_CPWT: begin
            wr_en = (i_ff[CNT_BITS-1:0] != last_ff);
            wr_addr = i_ff[PTR_BITS-1:0]; wr_data = rd_data;
         end
         S_INS_RD, S_INS_WT: rd_addr = fixed_ff[PTR_BITS-1:0];
         S_INS_W: begin
            wr_en = 1'b1; wr_addr = PTR_BITS'(kept_ff - 1'b1); wr_data = rd_data;
         end
         default: ;
      endcase
      if (state_ff == S_IDLE && hold_pending_ff) begin
         wr_en = 1'b1; wr_addr = hold_addr_ff; wr_data = hold_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rsp_valid_ff <= 1'b0; hold_pending_ff <= 1'b0;
         fixed_ff <= '0; kept_ff <= '0; spos_ff <= '0;
         start_ff <= '0; size_ff <= 12'd2048; nblk_ff <= 8'd128;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_START: start_ff <= csr_wdata[10:0];
               CSR_SIZE:  size_ff  <= csr_wdata;
               CSR_NBLK:  nblk_ff  <= csr_wdata[7:0];
               default: ;
            endcase
         end
         if (state_ff == S_DONE && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == S_IDLE) hold_pending_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_valid && !hold_pending_ff) begin
               req_ff <= req_data; i_ff <= '0; state_ff <= S_DISP;
            end
            S_DISP: begin
               res_ff <= '{status: ST_OK, tile_index: '0};
               find_free_ff <= (req_ff.func == FUNC_FREE);
               unique case (req_ff.func)
                  FUNC_ALLOC, FUNC_REALLOC, FUNC_LOOKUP: begin
                     lim_cnt_ff <= kept_ff; state_ff <= S_FIND_RD;
                  end
                  FUNC_FREE: begin lim_cnt_ff <= fixed_ff; state_ff <= S_FIND_RD; end
                  FUNC_FLUSH: begin fixed_ff <= '0; state_ff <= S_DONE; end
                  FUNC_CLEAR: begin
                     fixed_ff <= '0; kept_ff <= '0; spos_ff <= POS_BITS'(start_ff);
                     state_ff <= S_DONE;
                  end
                  default: state_ff <= S_DONE;
               endcase
            end
            S_FIND_RD: begin
               if (i_ff >= (CNT_BITS+1)'(lim_cnt_ff)) begin
                  if (req_ff.func == FUNC_ALLOC) begin
                     if (fixed_ff >= used) begin
                        res_ff.status <= ST_NO_ENTRY; state_ff <= S_DONE;
                     end else state_ff <= S_SRCH_INIT;
                  end else begin
                     res_ff.status <= ST_NOT_FOUND; state_ff <= S_DONE;
                  end
               end else state_ff <= S_FIND_WT;
            end
            S_FIND_WT: state_ff <= S_FIND_CHK;
            S_FIND_CHK: begin
               if (rd_data.key == req_ff.tileset_id) begin
                  hit_ff <= i_ff[CNT_BITS-1:0];
                  hold_ff <= rd_data;
                  if (req_ff.func == FUNC_LOOKUP) begin
                     res_ff.tile_index <= rd_data.base; state_ff <= S_DONE;
                  end else if (find_free_ff) begin
                     fixed_ff <= fixed_ff - 1'b1; last_ff <= fixed_ff - 1'b1;
                     if (kept_ff != '0) kept_ff <= kept_ff - 1'b1;
                     state_ff <= S_FR_RD;
                  end else begin
                     res_ff.tile_index <= rd_data.base;
                     if (i_ff[CNT_BITS-1:0] >= fixed_ff) begin
                        last_ff <= fixed_ff; fixed_ff <= fixed_ff + 1'b1;
                        state_ff <= S_REV_RD;
                     end else state_ff <= S_DONE;
                  end
               end else begin
                  i_ff <= i_ff + 1'b1; state_ff <= S_FIND_RD;
               end
            end
            S_REV_RD: state_ff <= S_REV_WT;
            S_REV_WT: state_ff <= S_REV_W1;
            S_REV_W1: begin
               hold_pending_ff <= 1'b1; hold_addr_ff <= last_ff[PTR_BITS-1:0];
               state_ff <= S_DONE;
            end
            S_FR_RD: state_ff <= S_FR_WT;
            S_FR_WT: state_ff <= S_FR_W1;
            S_FR_W1: begin
               hold_pending_ff <= 1'b1; hold_addr_ff <= last_ff[PTR_BITS-1:0];
               state_ff <= S_DONE;
            end
            S_SRCH_INIT: begin
               s_ff <= (POS_BITS+1)'(spos_ff); hi_pass_ff <= limit; pass2_ff <= 1'b0;
               i_ff <= '0; state_ff <= S_CF_RD;
            end
            S_CF_RD: begin
               if (!(s_end < hi_pass_ff)) begin
                  if (!pass2_ff) begin
                     pass2_ff <= 1'b1; s_ff <= start_x;
                     hi_pass_ff <= (POS_BITS+1)'(spos_ff); i_ff <= '0;
                  end else begin
                     res_ff.status <= ST_NO_SPACE; state_ff <= S_DONE;
                  end
               end else if (i_ff >= (CNT_BITS+1)'(fixed_ff)) begin
                  state_ff <= S_DR_INIT;
               end else state_ff <= S_CF_WT;
            end
            S_CF_WT: state_ff <= S_CF_CHK;
            S_CF_CHK: begin
               if (overlap) begin
                  s_ff <= e_end; i_ff <= '0;
               end else i_ff <= i_ff + 1'b1;
               state_ff <= S_CF_RD;
            end
            S_DR_INIT: begin
               res_ff.tile_index <= s_ff[INDEX_BITS-1:0];
               spos_ff <= s_end[POS_BITS-1:0];
               i_ff <= (CNT_BITS+1)'(kept_ff); last_ff <= kept_ff;
               state_ff <= S_DR_RD;
            end
            S_DR_RD: begin
               if (i_ff <= (CNT_BITS+1)'(fixed_ff)) begin
                  kept_ff <= last_ff; state_ff <= S_INS_RD;
               end else begin
                  i_ff <= i_ff - 1'b1; state_ff <= S_DR_WT;
               end
            end
            S_DR_WT: state_ff <= S_DR_CHK;
            S_DR_CHK: begin
               if (overlap) begin
                  last_ff <= last_ff - 1'b1; state_ff <= S_DR_CPWT;
               end else state_ff <= S_DR_RD;
            end
            S_DR_CPWT: state_ff <= S_DR_RD;
            S_INS_RD: state_ff <= S_INS_WT;
            S_INS_WT: begin
               hold_ff <= '{key: req_ff.tileset_id, base: s_ff[INDEX_BITS-1:0],
                            size: req_ff.tile_count};
               hold_addr_ff <= fixed_ff[PTR_BITS-1:0];
               fixed_ff <= fixed_ff + 1'b1;
               if (kept_ff < used) begin
                  kept_ff <= kept_ff + 1'b1; state_ff <= S_INS_W;
               end else begin
                  hold_pending_ff <= 1'b1; state_ff <= S_DONE;
               end
            end
            S_INS_W: begin hold_pending_ff <= 1'b1; state_ff <= S_DONE; end
            S_DONE: if (!rsp_valid_ff || !rsp_stall) begin
               rsp_ff <= res_ff; state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `TRC_ASSERT(a_fixed_le_kept, clock, reset, (state_ff == S_IDLE) |-> (fixed_ff <= kept_ff || kept_ff == '0 || fixed_ff <= CNT_BITS'(MAX_BLOCKS)), "fixed count above table")
   `TRC_ASSERT(a_kept_bound, clock, reset, kept_ff <= CNT_BITS'(MAX_BLOCKS), "kept count above table")
   `TRC_ASSERT(a_rsp_hold, clock, reset, (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_ff)), "stalled response changed")
   `TRC_ASSERT_NR(a_reset_idle, clock, reset |=> (state_ff == S_IDLE && !rsp_valid_ff), "not idle after reset")
endmodule

FILE: test/tb_tile_region_cache_allocator_top.sv
`timescale 1ns / 1ps
module tb_tile_region_cache_allocator_top;
   import trc_pkg::*;

   localparam int WATCHDOG = 1000000;
   localparam int TBL = 128;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_START;
   logic [11:0] csr_wdata = '0;

   tile_region_cache_allocator_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // allocator mirror
   int unsigned win_start = 0, win_size = 2048, blk_cfg = 128;
   logic [23:0] slot_key [TBL];
   int unsigned slot_base [TBL];
   int unsigned slot_size [TBL];
   int unsigned n_fixed = 0, n_kept = 0, scan_pos = 0;

   req_type     pending_reqs [$];
   rsp_type     expected_rsps [$];
   int          send_idle = 29, recv_idle = 65;
   int          n_err = 0;
   int          hold_left = 0;
   logic        hold_go = 1'b0;
   int          quiet_cycles = 0;

   function automatic int unsigned blocks_in_use();
      return blk_cfg > TBL ? TBL : blk_cfg;
   endfunction

   function automatic int find_slot(logic [23:0] key, int unsigned cnt);
      for (int i = 0; i < cnt && i < TBL; i++)
         if (slot_key[i] == key) return i;
      return -1;
   endfunction

   function automatic bit fixed_overlap(int unsigned lo, hi, output int unsigned nx);
      for (int i = 0; i < n_fixed && i < TBL; i++)
         if (slot_base[i] < hi && slot_base[i] + slot_size[i] > lo) begin
            nx = slot_base[i] + slot_size[i];
            return 1'b1;
         end
      return 1'b0;
   endfunction

   function automatic bit fit_range(int unsigned from, lim, sz, output int unsigned base);
      int unsigned s, nx;
      s = from;
      while (s + sz < lim) begin
         if (!fixed_overlap(s, s + sz, nx)) begin
            base = s;
            return 1'b1;
         end
         s = nx;
      end
      return 1'b0;
   endfunction

   function automatic void move_slot(int unsigned dst, src);
      slot_key[dst] = slot_key[src];
      slot_base[dst] = slot_base[src];
      slot_size[dst] = slot_size[src];
   endfunction

   function automatic void evict_overlaps(int unsigned lo, hi);
      int unsigned last, j;
      last = n_kept;
      j = n_kept;
      while (j > n_fixed) begin
         j--;
         if (slot_base[j] < hi && slot_base[j] + slot_size[j] > lo) begin
            last--;
            if (j != last) move_slot(j, last);
         end
      end
      n_kept = last;
   endfunction

   function automatic int unsigned pin_slot(int unsigned p);
      logic [23:0] k;
      int unsigned b, z;
      if (p >= n_fixed) begin
         if (p != n_fixed) begin
            k = slot_key[p]; b = slot_base[p]; z = slot_size[p];
            move_slot(p, n_fixed);
            slot_key[n_fixed] = k; slot_base[n_fixed] = b; slot_size[n_fixed] = z;
            p = n_fixed;
         end
         n_fixed++;
      end
      return p;
   endfunction

   function automatic rsp_type allocate_range(req_type r);
      rsp_type o;
      int p;
      int unsigned base, lim, sl, last, b, z;
      bit ok;
      o.status = ST_OK;
      o.tile_index = '0;
      case (r.func)
         FUNC_ALLOC, FUNC_REALLOC: begin
            p = find_slot(r.tileset_id, n_kept);
            if (p >= 0) begin
               o.tile_index = 11'(slot_base[pin_slot(p)]);
            end else if (r.func == FUNC_REALLOC) begin
               o.status = ST_NOT_FOUND;
            end else if (n_fixed >= blocks_in_use()) begin
               o.status = ST_NO_ENTRY;
            end else begin
               lim = win_start + win_size;
               if (lim > 2048) lim = 2048;
               ok = fit_range(scan_pos, lim, r.tile_count, base);
               if (!ok) ok = fit_range(win_start, scan_pos, r.tile_count, base);
               if (!ok) begin
                  o.status = ST_NO_SPACE;
               end else begin
                  scan_pos = (base + r.tile_count) & 12'hFFF;
                  evict_overlaps(base, base + r.tile_count);
                  sl = n_fixed;
                  n_fixed++;
                  if (n_kept < blocks_in_use()) begin
                     if (n_kept != sl) move_slot(n_kept, sl);
                     n_kept++;
                  end
                  slot_key[sl] = r.tileset_id;
                  slot_base[sl] = base & 11'h7FF;
                  slot_size[sl] = r.tile_count;
                  o.tile_index = 11'(base);
               end
            end
         end
         FUNC_FREE: begin
            p = find_slot(r.tileset_id, n_fixed);
            if (p >= 0) begin
               n_fixed--;
               last = n_fixed;
               if (last != p) begin
                  b = slot_base[p]; z = slot_size[p];
                  move_slot(p, last);
                  slot_key[last] = r.tileset_id; slot_base[last] = b; slot_size[last] = z;
               end
               if (n_kept > 0) n_kept--;
            end else begin
               o.status = ST_NOT_FOUND;
            end
         end
         FUNC_LOOKUP: begin
            p = find_slot(r.tileset_id, n_kept);
            if (p >= 0) o.tile_index = 11'(slot_base[p]);
            else o.status = ST_NOT_FOUND;
         end
         FUNC_FLUSH: n_fixed = 0;
         FUNC_CLEAR: begin
            n_fixed = 0;
            n_kept = 0;
            scan_pos = win_start;
         end
         default: ;
      endcase
      return o;
   endfunction

   // request driver
   logic req_fire;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         req_fire = req_valid && !req_stall;
         if (req_fire) expected_rsps.push_back(allocate_range(req_data));
         if (!req_valid || req_fire) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   rsp_type want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               n_err++;
               if (n_err <= 10) $display("unexpected beat: status %0d tile %0d",
                                         rsp_data.status, rsp_data.tile_index);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.status !== want.status || rsp_data.tile_index !== want.tile_index)
               begin
                  n_err++;
                  if (n_err <= 10)
                     $display("mismatch: exp status %0d tile %0d, got status %0d tile %0d",
                              want.status, want.tile_index, rsp_data.status,
                              rsp_data.tile_index);
               end
            end
         end
         if (hold_go) hold_left = 400;
         else if (hold_left > 0) hold_left--;
         rsp_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (pending_reqs.size() == 0 && expected_rsps.size() == 0 && !req_valid))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("tb_tile_region_cache_allocator_top: errors");
         $finish;
      end
   end

   task automatic push_req(logic [2:0] f, logic [23:0] k, logic [11:0] c);
      req_type r;
      r.func = f; r.tileset_id = k; r.tile_count = c;
      pending_reqs.push_back(r);
   endtask

   task automatic push_random(int n);
      int sel;
      logic [2:0] f;
      logic [23:0] k;
      logic [11:0] c;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(99);
         if (sel < 45) f = FUNC_ALLOC;
         else if (sel < 55) f = FUNC_REALLOC;
         else if (sel < 70) f = FUNC_FREE;
         else if (sel < 85) f = FUNC_LOOKUP;
         else if (sel < 91) f = FUNC_FLUSH;
         else if (sel < 95) f = FUNC_CLEAR;
         else f = 3'($urandom_range(7));
         if ($urandom_range(9) == 0) k = 24'($urandom);
         else k = 24'h5A0000 + 24'($urandom_range(15));
         sel = $urandom_range(99);
         if (sel < 80) c = 12'($urandom_range(40));
         else if (sel < 96) c = 12'($urandom_range(300));
         else c = 12'($urandom_range(2048));
         push_req(f, k, c);
      end
   endtask

   task automatic csr_write(logic [1:0] idx, int unsigned v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 12'(v);
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_START: win_start = v & 12'h7FF;
         CSR_SIZE:  win_size = v & 12'hFFF;
         CSR_NBLK:  blk_cfg = v & 12'hFF;
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_window(int unsigned s, z, nb);
      csr_write(CSR_START, s);
      csr_write(CSR_SIZE, z);
      csr_write(CSR_NBLK, nb);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      push_req(FUNC_ALLOC, 24'h000000, 12'd0);
      push_req(FUNC_ALLOC, 24'hFFFFFF, 12'd2048);
      push_req(FUNC_ALLOC, 24'h000001, 12'd2047);
      push_req(FUNC_LOOKUP, 24'h000001, 12'd0);
      push_req(FUNC_REALLOC, 24'h123456, 12'd5);
      push_req(FUNC_REALLOC, 24'h000001, 12'd5);
      push_req(FUNC_FREE, 24'h000001, 12'd0);
      push_req(FUNC_FREE, 24'h000001, 12'd0);
      push_req(FUNC_LOOKUP, 24'h000001, 12'd0);
      push_req(FUNC_ALLOC, 24'h000001, 12'd9);
      push_req(FUNC_FLUSH, 24'h000000, 12'd0);
      push_req(FUNC_LOOKUP, 24'h000000, 12'd0);
      push_req(FUNC_ALLOC, 24'h000000, 12'd4);
      push_req(FUNC_ALLOC, 24'h000002, 12'd100);
      push_req(FUNC_CLEAR, 24'h000000, 12'd0);
      push_req(3'd6, 24'hABCDEF, 12'hFFF);
      push_req(3'd7, 24'h000000, 12'd0);
      push_req(FUNC_LOOKUP, 24'h000001, 12'd0);
      push_req(FUNC_FREE, 24'hFFFFFF, 12'd0);
      drain();

      set_window(100, 600, 8);
      push_random(130);
      drain();

      set_window(2047, 2048, 0);
      push_random(20);
      drain();

      set_window(0, 2048, 255);
      push_req(FUNC_CLEAR, 24'h0, 12'd0);
      hold_go <= 1'b1;
      @(posedge clock);
      hold_go <= 1'b0;
      push_random(60);
      drain();

      send_idle = 65;
      recv_idle = 29;
      set_window(512, 1024, 4);
      push_req(FUNC_CLEAR, 24'h0, 12'd0);
      push_random(110);
      drain();

      set_window(300, 0, 1);
      push_random(10);
      drain();

      send_idle = 0;
      recv_idle = 0;
      set_window(0, 2048, 128);
      push_req(FUNC_CLEAR, 24'h0, 12'd0);
      push_random(110);
      drain();

      if (n_err == 0) begin
         $display("tb_tile_region_cache_allocator_top: clean");
      end else begin
         $display("tb_tile_region_cache_allocator_top: errors");
      end
      $finish;
   end
endmodule
